// ----- hw/rtl/irs_pkg.sv -----
// shared constants, types and the catmull-rom weight table of the image rescaler
// no dependencies
package irs_pkg;

  localparam int MAX_SRC_W  = 256;
  localparam int MAX_SRC_H  = 256;
  localparam int FRAC_W     = 8;
  localparam int FRAC_SCALE = 1 << FRAC_W;

  localparam int XW    = $clog2(MAX_SRC_W);
  localparam int YW    = $clog2(MAX_SRC_H);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;

  localparam int COORD_W = 12;
  localparam int SRC_N_W = 9;
  localparam int DST_N_W = 13;
  localparam int PIX_W   = 32;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 13;

  localparam int MUL_W = COORD_W + SRC_N_W;
  localparam int NUM_W = MUL_W + FRAC_W;
  localparam int IX_W  = NUM_W - FRAC_W;
  localparam int SX_W  = IX_W + 2;

  localparam int W_W   = FRAC_W + 2;
  localparam int R_W   = W_W + 8 + 2;
  localparam int ACC_W = W_W + R_W + 2;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_SRC_W  = 3'd0,
    CFG_SRC_H  = 3'd1,
    CFG_DST_W  = 3'd2,
    CFG_DST_H  = 3'd3,
    CFG_METHOD = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    M_NEAREST  = 2'd0,
    M_BILINEAR = 2'd1,
    M_BICUBIC  = 2'd2
  } method_e;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef logic [FRAC_SCALE-1:0][3:0][W_W-1:0] cr_tab_t;

  function automatic cr_tab_t cr_build();
    cr_tab_t tab;
    longint s, t, u, w0, w1, w2, w3;
    s = longint'(1) << FRAC_W;
    for (int ti = 0; ti < FRAC_SCALE; ti++) begin
      t  = longint'(ti);
      u  = s - t;
      w0 = -((t * u * u + s * s) >>> (2 * FRAC_W + 1));
      w3 = -((t * t * u + s * s) >>> (2 * FRAC_W + 1));
      w2 = (t * (s * s + 4 * t * s - 3 * t * t) + s * s) >>> (2 * FRAC_W + 1);
      w1 = s - w0 - w2 - w3;
      tab[ti][0] = W_W'(w0);
      tab[ti][1] = W_W'(w1);
      tab[ti][2] = W_W'(w2);
      tab[ti][3] = W_W'(w3);
    end
    return tab;
  endfunction

  localparam cr_tab_t CR_TAB = cr_build();

endpackage

// ----- hw/rtl/irs_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module irs_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/irs_div.sv -----
// restoring divider, one quotient bit per cycle, maps a coordinate to source position
// depends on irs_pkg
module irs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [irs_pkg::NUM_W-1:0]     num_i,
  input  logic [irs_pkg::DST_N_W-1:0]   den_i,
  output logic [irs_pkg::NUM_W-1:0]     quot_o,
  output logic                          done_o
);
  import irs_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DST_N_W-1:0] den_q;
  logic [DST_N_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;
  logic [DST_N_W:0]   trial;
  logic               ge;

  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DST_N_W'(trial - {1'b0, den_q}) : trial[DST_N_W-1:0];
    quo_d = {quo_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        busy_q <= cnt_q != CNT_W'(1);
        cnt_q  <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

// ----- hw/rtl/image_rescaler_three_modes.sv -----
// image rescaler, top level: frame memory, coordinate dividers, tap sequencer and accumulator
// a write word is taken while the block is idle; a compute word passes the bit-serial coordinate
// divider, then one frame read per tap (1 nearest, 4 bilinear, 16 bicubic) on the single port,
// then the row and column accumulate steps, and the result is loaded into the output register
// one compute in flight, the next word is taken the cycle after the result loads
// reset clears control and registers to src 256x256, dst 256x256, nearest; frame is not cleared
module image_rescaler_three_modes (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [irs_pkg::CFG_A_W-1:0]   cfg_idx_i,
  input  logic [irs_pkg::CFG_D_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [irs_pkg::COORD_W-1:0]   x_coord_i,
  input  logic [irs_pkg::COORD_W-1:0]   y_coord_i,
  input  logic [irs_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [irs_pkg::PIX_W-1:0]     pixel_out_o,
  output logic [irs_pkg::COORD_W-1:0]   out_x_o,
  output logic [irs_pkg::COORD_W-1:0]   out_y_o
);
  import irs_pkg::*;

  // configuration
  logic [SRC_N_W-1:0] src_w_q, src_h_q;
  logic [DST_N_W-1:0] dst_w_q, dst_h_q;
  logic [1:0]         method_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= SRC_N_W'(MAX_SRC_W);
      src_h_q  <= SRC_N_W'(MAX_SRC_H);
      dst_w_q  <= DST_N_W'(256);
      dst_h_q  <= DST_N_W'(256);
      method_q <= M_NEAREST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC_W: begin
          if (cfg_wdata_i[SRC_N_W-1:0] == '0) src_w_q <= SRC_N_W'(1);
          else if (cfg_wdata_i[SRC_N_W-1:0] > SRC_N_W'(MAX_SRC_W))
            src_w_q <= SRC_N_W'(MAX_SRC_W);
          else src_w_q <= cfg_wdata_i[SRC_N_W-1:0];
        end
        CFG_SRC_H: begin
          if (cfg_wdata_i[SRC_N_W-1:0] == '0) src_h_q <= SRC_N_W'(1);
          else if (cfg_wdata_i[SRC_N_W-1:0] > SRC_N_W'(MAX_SRC_H))
            src_h_q <= SRC_N_W'(MAX_SRC_H);
          else src_h_q <= cfg_wdata_i[SRC_N_W-1:0];
        end
        CFG_DST_W:  dst_w_q  <= (cfg_wdata_i == '0) ? DST_N_W'(1) : cfg_wdata_i;
        CFG_DST_H:  dst_h_q  <= (cfg_wdata_i == '0) ? DST_N_W'(1) : cfg_wdata_i;
        CFG_METHOD: method_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // control
  state_e state_q, state_d;
  logic   in_acc, is_comp;
  logic   fetch_last, issue;
  logic   load_out;
  logic   done_q;
  logic [1:0] i_q, j_q, last_tap;
  logic [1:0] mode_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic   div_start, dx_done, dy_done;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign is_comp = opcode_i == OP_COMPUTE;

  always_comb begin
    unique case (mode_q)
      M_BICUBIC:  last_tap = 2'd3;
      M_BILINEAR: last_tap = 2'd1;
      default:    last_tap = 2'd0;
    endcase
  end

  assign fetch_last = (i_q == last_tap) && (j_q == last_tap);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i && is_comp) state_d = ST_DIV;
      ST_DIV:    if (dx_done) state_d = ST_FETCH;
      ST_FETCH:  if (fetch_last) state_d = ST_DRAIN;
      ST_DRAIN:  if (done_q) state_d = ST_FINISH;
      ST_FINISH: if (!out_valid_o || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = state_q != ST_IDLE;
    div_start  = (state_q == ST_IDLE) && in_valid_i && is_comp;
    issue      = state_q == ST_FETCH;
    load_out   = (state_q == ST_FINISH) && (!out_valid_o || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != ST_FETCH) begin
        i_q <= '0;
        j_q <= '0;
      end else if (i_q == last_tap) begin
        i_q <= '0;
        j_q <= j_q + 2'd1;
      end else begin
        i_q <= i_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      x_q    <= x_coord_i;
      y_q    <= y_coord_i;
      mode_q <= method_q;
    end
  end

  // coordinate mapping
  logic [NUM_W-1:0] num_x, num_y, qx, qy;
  logic [MUL_W-1:0] mx, my;

  assign mx    = MUL_W'(x_coord_i) * MUL_W'(src_w_q);
  assign my    = MUL_W'(y_coord_i) * MUL_W'(src_h_q);
  assign num_x = {mx, {FRAC_W{1'b0}}};
  assign num_y = {my, {FRAC_W{1'b0}}};

  irs_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_x),
    .den_i   (dst_w_q),
    .quot_o  (qx),
    .done_o  (dx_done)
  );

  irs_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_y),
    .den_i   (dst_h_q),
    .quot_o  (qy),
    .done_o  (dy_done)
  );

  // tap address and weights
  logic [FRAC_W-1:0]   fx, fy;
  logic signed [2:0]   offx, offy;
  logic signed [SX_W-1:0] cx_s, cy_s;
  logic [XW-1:0]       cx;
  logic [YW-1:0]       cy;
  logic signed [W_W-1:0] wx, wy;

  assign fx = qx[FRAC_W-1:0];
  assign fy = qy[FRAC_W-1:0];

  always_comb begin
    offx = $signed({1'b0, i_q});
    offy = $signed({1'b0, j_q});
    if (mode_q == M_BICUBIC) begin
      offx = offx - 3'sd1;
      offy = offy - 3'sd1;
    end
    cx_s = $signed({2'b00, qx[NUM_W-1:FRAC_W]}) + SX_W'(offx);
    cy_s = $signed({2'b00, qy[NUM_W-1:FRAC_W]}) + SX_W'(offy);
    if (cx_s < 0) cx = '0;
    else if (cx_s >= $signed(SX_W'(src_w_q))) cx = XW'(src_w_q - SRC_N_W'(1));
    else cx = cx_s[XW-1:0];
    if (cy_s < 0) cy = '0;
    else if (cy_s >= $signed(SX_W'(src_h_q))) cy = YW'(src_h_q - SRC_N_W'(1));
    else cy = cy_s[YW-1:0];
  end

  always_comb begin
    case (mode_q)
      M_BICUBIC: begin
        wx = $signed(CR_TAB[fx][i_q]);
        wy = $signed(CR_TAB[fy][j_q]);
      end
      M_BILINEAR: begin
        wx = (i_q == 2'd0) ? W_W'(FRAC_SCALE - int'(fx)) : $signed(W_W'(fx));
        wy = (j_q == 2'd0) ? W_W'(FRAC_SCALE - int'(fy)) : $signed(W_W'(fy));
      end
      default: begin
        wx = W_W'(FRAC_SCALE);
        wy = W_W'(FRAC_SCALE);
      end
    endcase
  end

  // frame memory
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [PIX_W-1:0] ram_rdata;

  assign ram_we = in_acc && !is_comp &&
                  (x_coord_i < COORD_W'(MAX_SRC_W)) && (y_coord_i < COORD_W'(MAX_SRC_H));
  assign ram_addr = issue ? {cy, cx} : {y_coord_i[YW-1:0], x_coord_i[XW-1:0]};

  irs_ram #(
    .Width (PIX_W),
    .Depth (DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (pixel_in_i),
    .rdata_o (ram_rdata)
  );

  // accumulate: row sums along x, then the weighted sum of those rows along y
  logic                  s1_v_q, s1_first_q, s1_rowend_q, s1_firstrow_q, s1_last_q;
  logic signed [W_W-1:0] s1_wx_q, s1_wy_q;
  logic                  s2_v_q, s2_firstrow_q, s2_last_q;
  logic signed [W_W-1:0] s2_wy_q;
  logic signed [R_W-1:0]   r_q   [4];
  logic signed [ACC_W-1:0] acc_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q && s1_rowend_q;
      if (div_start) done_q <= 1'b0;
      else if (s2_v_q && s2_last_q) done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_wx_q       <= wx;
    s1_wy_q       <= wy;
    s1_first_q    <= i_q == 2'd0;
    s1_rowend_q   <= i_q == last_tap;
    s1_firstrow_q <= j_q == 2'd0;
    s1_last_q     <= fetch_last;
    s2_wy_q       <= s1_wy_q;
    s2_firstrow_q <= s1_firstrow_q;
    s2_last_q     <= s1_last_q;
    for (int k = 0; k < 4; k++) begin
      if (s1_v_q) begin
        r_q[k] <= (s1_first_q ? R_W'(0) : r_q[k]) +
                  R_W'(s1_wx_q) * R_W'($signed({1'b0, ram_rdata[8*k +: 8]}));
      end
      if (s2_v_q) begin
        acc_q[k] <= (s2_firstrow_q ? ACC_W'(0) : acc_q[k]) +
                    ACC_W'(s2_wy_q) * ACC_W'(r_q[k]);
      end
    end
  end

  // round, saturate and pack
  logic [PIX_W-1:0] pix;
  logic signed [ACC_W-1:0] rnd [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rnd[k] = acc_q[k] + ACC_W'(1 << (2 * FRAC_W - 1));
      if (acc_q[k] < 0) pix[8*k +: 8] = 8'd0;
      else if ((rnd[k] >>> (2 * FRAC_W)) > ACC_W'(255)) pix[8*k +: 8] = 8'd255;
      else pix[8*k +: 8] = rnd[k][2*FRAC_W +: 8];
    end
  end

  // output register
  logic               out_valid_q;
  logic [PIX_W-1:0]   pixel_q;
  logic [COORD_W-1:0] ox_q, oy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pixel_q <= pix;
      ox_q    <= x_q;
      oy_q    <= y_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;

`ifndef SYNTHESIS
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dx_done |-> (state_q == ST_DIV && dy_done))
    else $error("divider finished outside divide phase");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE))
    else $error("frame write while a compute is running");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result appeared without a finished compute");

  a_s2_after_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> $past(s1_v_q))
    else $error("row sum step without a tap");
`endif

endmodule

// ----- verif/irs_checker.sv -----
// checker of the image rescaler testbench: watches config, input and output channels,
// predicts each resampled pixel and compares it; depends on irs_pkg
`timescale 1ns / 100ps
module irs_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [irs_pkg::CFG_A_W-1:0]  cfg_idx_i,
  input  logic [irs_pkg::CFG_D_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         opcode_i,
  input  logic [irs_pkg::COORD_W-1:0]  x_coord_i,
  input  logic [irs_pkg::COORD_W-1:0]  y_coord_i,
  input  logic [irs_pkg::PIX_W-1:0]    pixel_in_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [irs_pkg::PIX_W-1:0]    pixel_out_i,
  input  logic [irs_pkg::COORD_W-1:0]  out_x_i,
  input  logic [irs_pkg::COORD_W-1:0]  out_y_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import irs_pkg::*;

  typedef struct {
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pixel_word_t;

  logic [PIX_W-1:0] frame [DEPTH];
  longint src_w = 256, src_h = 256, dst_w = 256, dst_h = 256;
  logic [1:0] mode = M_NEAREST;
  pixel_word_t awaited_pixels [$];
  int fails = 0;

  assign fail_count_o = fails;

  function automatic longint clamp_src(longint v);
    v = v & 'h1FF;
    if (v < 1) return 1;
    if (v > MAX_SRC_W) return MAX_SRC_W;
    return v;
  endfunction

  function automatic longint pick(logic [PIX_W-1:0] p, int k);
    return longint'((p >> (8 * k)) & 'hFF);
  endfunction

  function automatic logic [PIX_W-1:0] tap(longint cx, longint cy);
    if (cx < 0) cx = 0;
    if (cx > src_w - 1) cx = src_w - 1;
    if (cy < 0) cy = 0;
    if (cy > src_h - 1) cy = src_h - 1;
    return frame[cy * MAX_SRC_W + cx];
  endfunction

  function automatic longint round_div(longint n, longint d);
    return (n + d / 2) / d;
  endfunction

  function automatic void spline_weights(longint t, output longint w [4]);
    longint s, d, u;
    s = FRAC_SCALE;
    d = 2 * s * s;
    u = s - t;
    w[0] = -round_div(t * u * u, d);
    w[3] = -round_div(t * t * u, d);
    w[2] = round_div(t * (s * s + 4 * t * s - 3 * t * t), d);
    w[1] = s - w[0] - w[2] - w[3];
  endfunction

  function automatic logic [7:0] saturate(longint v);
    longint r;
    if (v < 0) return 8'd0;
    r = (v + (longint'(1) << (2 * FRAC_W - 1))) >>> (2 * FRAC_W);
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic logic [PIX_W-1:0] resample(longint dx, longint dy);
    longint px, py, ix, iy, fx, fy, top, bot, acc, row;
    longint wx [4];
    longint wy [4];
    logic [PIX_W-1:0] res;
    res = '0;
    px = ((dx * src_w) << FRAC_W) / dst_w;
    py = ((dy * src_h) << FRAC_W) / dst_h;
    ix = px >>> FRAC_W;
    iy = py >>> FRAC_W;
    fx = px & (FRAC_SCALE - 1);
    fy = py & (FRAC_SCALE - 1);
    if (mode == M_BILINEAR) begin
      for (int k = 0; k < 4; k++) begin
        top = pick(tap(ix, iy), k) * (FRAC_SCALE - fx) + pick(tap(ix + 1, iy), k) * fx;
        bot = pick(tap(ix, iy + 1), k) * (FRAC_SCALE - fx) + pick(tap(ix + 1, iy + 1), k) * fx;
        res[8*k +: 8] = saturate(top * (FRAC_SCALE - fy) + bot * fy);
      end
    end else if (mode == M_BICUBIC) begin
      spline_weights(fx, wx);
      spline_weights(fy, wy);
      for (int k = 0; k < 4; k++) begin
        acc = 0;
        for (int j = 0; j < 4; j++) begin
          row = 0;
          for (int i = 0; i < 4; i++) row += wx[i] * pick(tap(ix + i - 1, iy + j - 1), k);
          acc += wy[j] * row;
        end
        res[8*k +: 8] = saturate(acc);
      end
    end else begin
      res = tap(ix, iy);
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    pixel_word_t exp_w;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SRC_W:  src_w = clamp_src(cfg_wdata_i);
          CFG_SRC_H:  src_h = clamp_src(cfg_wdata_i);
          CFG_DST_W:  dst_w = (cfg_wdata_i == 0) ? 1 : cfg_wdata_i;
          CFG_DST_H:  dst_h = (cfg_wdata_i == 0) ? 1 : cfg_wdata_i;
          CFG_METHOD: mode = cfg_wdata_i[1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_WRITE) begin
          if (x_coord_i < MAX_SRC_W && y_coord_i < MAX_SRC_H)
            frame[y_coord_i * MAX_SRC_W + x_coord_i] = pixel_in_i;
        end else begin
          exp_w.pix = resample(x_coord_i, y_coord_i);
          exp_w.x = x_coord_i;
          exp_w.y = y_coord_i;
          awaited_pixels.push_back(exp_w);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_pixels.size() == 0) begin
          if (fails < 10) $display("unexpected word: pixel %h at (%0d,%0d)",
                                   pixel_out_i, out_x_i, out_y_i);
          fails++;
        end else begin
          exp_w = awaited_pixels.pop_front();
          if (exp_w.pix !== pixel_out_i || exp_w.x !== out_x_i || exp_w.y !== out_y_i) begin
            if (fails < 10)
              $display("word mismatch: expected pixel %h (%0d,%0d), got %h (%0d,%0d)",
                       exp_w.pix, exp_w.x, exp_w.y, pixel_out_i, out_x_i, out_y_i);
            fails++;
          end
        end
      end
    end
    pending_o = awaited_pixels.size();
  end

endmodule

// ----- verif/tb.sv -----
// top of the image rescaler testbench: clock, reset, config phases, stimulus and verdict
// depends on irs_pkg, image_rescaler_three_modes and irs_checker
`timescale 1ns / 100ps
module tb;
  import irs_pkg::*;

  localparam logic [CFG_A_W-1:0] CFG_UNUSED = 3'd7;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_A_W-1:0] cfg_idx;
  logic [CFG_D_W-1:0] cfg_wdata;
  logic in_valid, in_stall, opcode;
  logic [COORD_W-1:0] x_coord, y_coord, out_x, out_y;
  logic [PIX_W-1:0] pixel_in, pixel_out;
  logic out_valid, out_stall;
  int fail_count, pending;

  bit written [DEPTH];
  int eff_w, eff_h, eff_dw, eff_dh;
  int sent_items = 0;
  bit gaps_on = 1, stalls_on = 1;

  image_rescaler_three_modes u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .opcode_i(opcode),
    .x_coord_i(x_coord), .y_coord_i(y_coord), .pixel_in_i(pixel_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pixel_out_o(pixel_out), .out_x_o(out_x), .out_y_o(out_y)
  );

  irs_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .opcode_i(opcode),
    .x_coord_i(x_coord), .y_coord_i(y_coord), .pixel_in_i(pixel_in),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .pixel_out_i(pixel_out), .out_x_i(out_x), .out_y_i(out_y),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // receiver backpressure
  initial begin
    int hold;
    hold = 0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!stalls_on) begin
        out_stall = 0;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
        out_stall = 1;
      end else begin
        hold = gap_len();
        out_stall = (hold > 0);
        if (hold > 0) hold--;
      end
    end
  end

  task automatic send_word(opcode_e op, int x, int y, logic [PIX_W-1:0] p);
    int g;
    g = gaps_on ? gap_len() : 0;
    repeat (g) begin
      @(negedge clk);
      in_valid = 0;
    end
    @(negedge clk);
    in_valid = 1;
    opcode = op;
    x_coord = COORD_W'(x);
    y_coord = COORD_W'(y);
    pixel_in = p;
    do @(posedge clk); while (in_stall);
    sent_items++;
    if (op == OP_WRITE && x < MAX_SRC_W && y < MAX_SRC_H) written[y * MAX_SRC_W + x] = 1;
  endtask

  task automatic drain(bit settle_cycles);
    @(negedge clk);
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    if (settle_cycles) repeat (60) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_A_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we = 1;
    cfg_idx = idx;
    cfg_wdata = CFG_D_W'(val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic logic [PIX_W-1:0] fill_value();
    case ($urandom_range(0, 3))
      0: return '1;
      1: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic set_mode(int sw, int sh, int dw, int dh, int m);
    drain(1);
    cfg_write(CFG_SRC_W, sw);
    cfg_write(CFG_SRC_H, sh);
    cfg_write(CFG_DST_W, dw);
    cfg_write(CFG_DST_H, dh);
    cfg_write(CFG_METHOD, m);
    eff_w = sw & 'h1FF;
    eff_w = (eff_w < 1) ? 1 : (eff_w > MAX_SRC_W) ? MAX_SRC_W : eff_w;
    eff_h = sh & 'h1FF;
    eff_h = (eff_h < 1) ? 1 : (eff_h > MAX_SRC_H) ? MAX_SRC_H : eff_h;
    eff_dw = (dw == 0) ? 1 : dw;
    eff_dh = (dh == 0) ? 1 : dh;
    gaps_on = ($urandom_range(0, 3) != 0);
    stalls_on = ($urandom_range(0, 3) != 0);
    // every pixel a compute can reach is written first
    for (int y = 0; y < eff_h; y++)
      for (int x = 0; x < eff_w; x++)
        if (!written[y * MAX_SRC_W + x]) send_word(OP_WRITE, x, y, fill_value());
  endtask

  task automatic random_words(int n, bit pause_midway);
    int r, x, y;
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain(0);
      r = $urandom_range(0, 99);
      if (r < 30) begin
        r = $urandom_range(0, 9);
        x = (r < 7) ? $urandom_range(0, eff_w - 1) : (r < 9) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 4095);
        y = (r < 7) ? $urandom_range(0, eff_h - 1) : (r < 9) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 4095);
        send_word(OP_WRITE, x, y, $urandom);
      end else begin
        r = $urandom_range(0, 9);
        x = (r < 8) ? $urandom_range(0, eff_dw + 2) : $urandom_range(0, 4095);
        y = (r < 8) ? $urandom_range(0, eff_dh + 2) : $urandom_range(0, 4095);
        send_word(OP_COMPUTE, x, y, $urandom);
      end
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_idx = CFG_SRC_W;
    cfg_wdata = 0;
    in_valid = 0;
    opcode = OP_WRITE;
    x_coord = 0;
    y_coord = 0;
    pixel_in = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    cfg_write(CFG_UNUSED, 'h1FFF);
    set_mode(4, 4, 8, 8, M_NEAREST);
    send_word(OP_WRITE, 4095, 0, '1);
    send_word(OP_WRITE, 0, 256, '0);
    send_word(OP_WRITE, 255, 255, 32'hA5C3_3C5A);
    send_word(OP_COMPUTE, 0, 0, '0);
    send_word(OP_COMPUTE, 4095, 4095, '1);
    send_word(OP_COMPUTE, 7, 0, '0);
    set_mode(4, 4, 'h1FFF, 0, M_BILINEAR);
    for (int i = 0; i < 6; i++) send_word(OP_COMPUTE, i * 800, i, '0);
    send_word(OP_COMPUTE, 4095, 4095, '0);
    set_mode('h1FF, 1, 4096, 3, M_BICUBIC);
    for (int i = 0; i < 6; i++) send_word(OP_COMPUTE, i * 819, i, '0);
    random_words(40, 1);
    set_mode(1, 'h1FF, 1, 4096, 3);
    for (int i = 0; i < 4; i++) send_word(OP_COMPUTE, 4095 - i, i * 1365, '0);
    set_mode(0, 0, 1, 1, M_BICUBIC);
    send_word(OP_COMPUTE, 0, 0, '0);
    send_word(OP_COMPUTE, 4095, 4095, '0);

    while (sent_items < 1700)
      set_mode_and_run();

    drain(1);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  task automatic set_mode_and_run();
    set_mode($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 64),
             $urandom_range(1, 64), $urandom_range(0, 3));
    random_words(150, 0);
  endtask

endmodule
